// ----- rtl/icmp_er_pkg.sv -----
`timescale 1ns / 1ps

package icmp_er_pkg;

  // ICMP type codes
  localparam logic [7:0] TYPE_ECHO       = 8'd8;
  localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;

  // Byte positions within a message (saturating counter)
  localparam logic [2:0] POS_TYPE     = 3'd0;
  localparam logic [2:0] POS_CSUM_HI  = 3'd2;
  localparam logic [2:0] POS_CSUM_LO  = 3'd3;
  localparam logic [2:0] POS_IDENT_HI = 3'd4;
  localparam logic [2:0] POS_IDENT_LO = 3'd5;
  localparam logic [2:0] POS_MAX      = 3'd7;

  // Incremental checksum fix-up for type 8 -> type 0
  localparam logic [15:0] CSUM_WRAP_LIMIT = 16'hF7FF;
  localparam logic [15:0] CSUM_ADJ        = 16'h0800;
  localparam logic [15:0] CSUM_ADJ_WRAP   = 16'h0801;

  // Verdict codes
  localparam logic [1:0] VERDICT_ANSWERED    = 2'd0;
  localparam logic [1:0] VERDICT_REPLY_SEEN  = 2'd1;
  localparam logic [1:0] VERDICT_UNSUPPORTED = 2'd2;
  localparam logic [1:0] VERDICT_TRUNCATED   = 2'd3;

  // Result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Per-message classification
  typedef enum logic [3:0] {
    MODE_NONE  = 4'b0001,
    MODE_ECHO  = 4'b0010,
    MODE_REPLY = 4'b0100,
    MODE_DROP  = 4'b1000
  } mode_t;

  // Work record for one accepted byte: up to two data bytes plus a verdict
  typedef struct packed {
    logic [1:0]  byte_cnt;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic        has_verdict;
    logic [1:0]  verdict;
    logic [15:0] ident;
    logic [31:0] rx_total;
    logic [31:0] tx_total;
  } op_t;

  // One result transfer
  typedef struct packed {
    logic        kind;
    logic [7:0]  reply_byte;
    logic        end_of_run;
    logic [1:0]  verdict;
    logic [15:0] reply_ident;
    logic [31:0] received_total;
    logic [31:0] answered_total;
  } res_t;

endpackage

// ----- rtl/icmp_er_front.sv -----
`timescale 1ns / 1ps

module icmp_er_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last,
  input  logic                in_push,
  input  logic                q_full,
  output logic                q_wr,
  output icmp_er_pkg::op_t    q_op
);

  logic [2:0]         pos_r, pos_nxt;
  icmp_er_pkg::mode_t mode_r, mode_nxt, mode_cur;
  logic [7:0]         held_r, held_nxt;
  logic [15:0]        ident_r, ident_nxt;
  logic [31:0]        rx_r, rx_nxt;
  logic [31:0]        tx_r, tx_nxt;
  logic [15:0]        csum_in;
  logic [15:0]        csum_out;
  logic               accept;
  icmp_er_pkg::op_t   op;

  assign accept = in_push && !q_full;

  // Checksum fix-up: one 16-bit compare and add
  assign csum_in  = {held_r, in_data_byte};
  assign csum_out = (csum_in >= icmp_er_pkg::CSUM_WRAP_LIMIT) ?
                    csum_in + icmp_er_pkg::CSUM_ADJ_WRAP :
                    csum_in + icmp_er_pkg::CSUM_ADJ;

  // Classify the byte and build its work record
  always_comb begin
    pos_nxt   = pos_r;
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    ident_nxt = ident_r;
    rx_nxt    = rx_r;
    tx_nxt    = tx_r;
    op        = '0;
    mode_cur  = mode_r;

    if (pos_r == icmp_er_pkg::POS_TYPE) begin
      rx_nxt = rx_r + 32'd1;
      if (in_data_byte == icmp_er_pkg::TYPE_ECHO) begin
        mode_cur    = icmp_er_pkg::MODE_ECHO;
        op.byte_cnt = 2'd1;
        op.byte0    = icmp_er_pkg::TYPE_ECHO_REPLY;
      end else if (in_data_byte == icmp_er_pkg::TYPE_ECHO_REPLY) begin
        mode_cur = icmp_er_pkg::MODE_REPLY;
      end else begin
        mode_cur = icmp_er_pkg::MODE_DROP;
      end
    end else begin
      case (mode_r)
        icmp_er_pkg::MODE_ECHO: begin
          if (pos_r == icmp_er_pkg::POS_CSUM_HI) begin
            held_nxt = in_data_byte;
          end else if (pos_r == icmp_er_pkg::POS_CSUM_LO) begin
            op.byte_cnt = 2'd2;
            op.byte0    = csum_out[15:8];
            op.byte1    = csum_out[7:0];
          end else begin
            op.byte_cnt = 2'd1;
            op.byte0    = in_data_byte;
          end
        end
        icmp_er_pkg::MODE_REPLY: begin
          if (pos_r == icmp_er_pkg::POS_IDENT_HI) begin
            ident_nxt = {in_data_byte, ident_r[7:0]};
          end else if (pos_r == icmp_er_pkg::POS_IDENT_LO) begin
            ident_nxt = {ident_r[15:8], in_data_byte};
          end
        end
        default: ;
      endcase
    end
    mode_nxt = mode_cur;

    // Verdict on the final byte
    if (in_last) begin
      op.has_verdict = 1'b1;
      case (mode_cur)
        icmp_er_pkg::MODE_ECHO: begin
          op.verdict = (pos_r >= icmp_er_pkg::POS_CSUM_LO) ?
                       icmp_er_pkg::VERDICT_ANSWERED : icmp_er_pkg::VERDICT_TRUNCATED;
        end
        icmp_er_pkg::MODE_REPLY: begin
          if (pos_r >= icmp_er_pkg::POS_IDENT_LO) begin
            op.verdict = icmp_er_pkg::VERDICT_REPLY_SEEN;
            op.ident   = ident_nxt;
          end else begin
            op.verdict = icmp_er_pkg::VERDICT_TRUNCATED;
          end
        end
        default: op.verdict = icmp_er_pkg::VERDICT_UNSUPPORTED;
      endcase
      if (op.verdict == icmp_er_pkg::VERDICT_ANSWERED) begin
        tx_nxt = tx_r + 32'd1;
      end
      op.rx_total = rx_nxt;
      op.tx_total = tx_nxt;
      pos_nxt     = icmp_er_pkg::POS_TYPE;
      mode_nxt    = icmp_er_pkg::MODE_NONE;
    end else begin
      pos_nxt = (pos_r < icmp_er_pkg::POS_MAX) ? pos_r + 3'd1 : icmp_er_pkg::POS_MAX;
    end
  end

  // Only records that carry results go into the queue
  assign q_wr = accept && ((op.byte_cnt != 2'd0) || op.has_verdict);
  assign q_op = op;

  // Message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= icmp_er_pkg::POS_TYPE;
      mode_r  <= icmp_er_pkg::MODE_NONE;
      held_r  <= '0;
      ident_r <= '0;
      rx_r    <= '0;
      tx_r    <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      mode_r  <= mode_nxt;
      held_r  <= held_nxt;
      ident_r <= ident_nxt;
      rx_r    <= rx_nxt;
      tx_r    <= tx_nxt;
    end
  end

  // A fresh message position always pairs with no active mode
  a_pos_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == icmp_er_pkg::POS_TYPE) |-> (mode_r == icmp_er_pkg::MODE_NONE))
    else $error("front: mode set at message start");

  // Answered count moves only with a verdict transfer
  a_tx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !(in_last && op.verdict == icmp_er_pkg::VERDICT_ANSWERED)) |=>
    $stable(tx_r))
    else $error("front: answered count moved without an answered verdict");

endmodule

// ----- rtl/icmp_er_queue.sv -----
`timescale 1ns / 1ps

module icmp_er_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  icmp_er_pkg::op_t wr_op,
  output logic             full,
  input  logic             rd,
  output icmp_er_pkg::op_t rd_op,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  icmp_er_pkg::op_t entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_wr     = wr && !full;
  assign do_rd     = rd && not_empty;
  assign rd_op     = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_op;
    end
  end

  // The front must never offer a record into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && full))
    else $error("queue: write while full");

endmodule

// ----- rtl/icmp_er_back.sv -----
`timescale 1ns / 1ps

module icmp_er_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  icmp_er_pkg::op_t  q_op,
  output logic              q_rd,
  input  logic              out_pop,
  output logic              out_valid,
  output icmp_er_pkg::res_t out_res
);

  logic [1:0]        idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  icmp_er_pkg::res_t res_r, res_sel;
  logic [1:0]        n_res;
  logic              last_res;
  logic              load;

  assign n_res    = q_op.byte_cnt + {1'b0, q_op.has_verdict};
  assign last_res = (idx_r == n_res - 2'd1);
  assign load     = q_valid && (!valid_r || out_pop);
  assign q_rd     = load && last_res;

  // Pick the result at the current index of the head record
  always_comb begin
    res_sel = '0;
    if (idx_r < q_op.byte_cnt) begin
      res_sel.kind       = icmp_er_pkg::KIND_DATA;
      res_sel.reply_byte = (idx_r == 2'd0) ? q_op.byte0 : q_op.byte1;
    end else begin
      res_sel.kind           = icmp_er_pkg::KIND_VERDICT;
      res_sel.end_of_run     = 1'b1;
      res_sel.verdict        = q_op.verdict;
      res_sel.reply_ident    = q_op.ident;
      res_sel.received_total = q_op.rx_total;
      res_sel.answered_total = q_op.tx_total;
    end
  end

  // Output register and index sequencing
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = last_res ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_sel;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Records in the queue always carry at least one result
  a_nonempty_op: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (n_res != 2'd0))
    else $error("back: empty record at queue head");

  // Mid-record index implies the record is still at the head
  a_idx_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> (q_valid && idx_r < n_res))
    else $error("back: result index without a matching record");

endmodule

// ----- rtl/icmp_echo_responder_core.sv -----
`timescale 1ns / 1ps

// ICMPv4 echo responder. Takes one message byte per cycle while full is low
// (push/full) and returns results through a queue-style port (empty/pop): echo
// reply bytes followed by one verdict per message carrying the running receive
// and answer counts. The byte that completes the checksum yields two results
// (three if it also ends the message) and every message adds its verdict, so
// an echo gives one result more than it has bytes. A QUEUE_DEPTH record queue
// between the classifier and the result sequencer, which emits one result per
// cycle while results are popped, absorbs these bursts. With results popped
// every cycle, input runs at one byte per cycle until the queue fills during a
// long run of echoes; from then on the extra result of each echo stalls the
// input. full rises only while the queue holds QUEUE_DEPTH records. A result
// passes through a queue record and then the output register to the output.

module icmp_echo_responder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  input  logic        push,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [7:0]  out_reply_byte,
  output logic        out_end_of_run,
  output logic [1:0]  out_verdict,
  output logic [15:0] out_reply_ident,
  output logic [31:0] out_received_total,
  output logic [31:0] out_answered_total
);

  logic              q_full, q_wr, q_rd, q_valid;
  icmp_er_pkg::op_t  q_wr_op, q_rd_op;
  logic              res_valid;
  icmp_er_pkg::res_t res;

  // Classifier: tracks message position and builds work records
  icmp_er_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .in_push      (push),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_op         (q_wr_op)
  );

  // Record queue between the two halves
  icmp_er_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (q_wr),
    .wr_op     (q_wr_op),
    .full      (q_full),
    .rd        (q_rd),
    .rd_op     (q_rd_op),
    .not_empty (q_valid)
  );

  // Result sequencer with output register
  icmp_er_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_rd_op),
    .q_rd      (q_rd),
    .out_pop   (pop),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign full               = q_full;
  assign empty              = !res_valid;
  assign out_kind           = res.kind;
  assign out_reply_byte     = res.reply_byte;
  assign out_end_of_run     = res.end_of_run;
  assign out_verdict        = res.verdict;
  assign out_reply_ident    = res.reply_ident;
  assign out_received_total = res.received_total;
  assign out_answered_total = res.answered_total;

endmodule
